// File: hdl/dpe_pkg.sv
// Shared constants, types and codes for the distinct permutation enumerator.
// No dependencies; the interface file and the core import this package.
package dpe_pkg;

    // Store geometry and value width
    localparam int MAX_ITEMS  = 8;
    localparam int VALUE_BITS = 16;
    localparam int IDX_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W      = 4;   // count and config register width
    localparam int OUT_ELEMS  = 8;   // element slots in one result word
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_NEXT = 1'b1;

    // Register index codes (paddr[2])
    localparam logic REG_ITEM_COUNT   = 1'b0;
    localparam logic REG_TUPLE_LENGTH = 1'b1;

endpackage

// File: hdl/dpe_ifs.sv
// Valid/ready channel interfaces for the request and result words.
// Depends on dpe_pkg for the value type.
interface dpe_req_if
    import dpe_pkg::*;
;
    logic   valid;
    logic   ready;
    logic   req_type;
    value_t value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface dpe_res_if
    import dpe_pkg::*;
;
    logic   valid;
    logic   ready;
    value_t elem_0;
    value_t elem_1;
    value_t elem_2;
    value_t elem_3;
    value_t elem_4;
    value_t elem_5;
    value_t elem_6;
    value_t elem_7;
    logic   exhausted;

    modport source (output valid, output elem_0, output elem_1, output elem_2,
                    output elem_3, output elem_4, output elem_5, output elem_6,
                    output elem_7, output exhausted, input ready);
    modport sink   (input valid, input elem_0, input elem_1, input elem_2,
                    input elem_3, input elem_4, input elem_5, input elem_6,
                    input elem_7, input exhausted, output ready);
endinterface

// File: hdl/distinct_permutation_enumerator_core.sv
// Distinct ordered-selection enumerator over a small sorted multiset.
// Depends on dpe_pkg and the channel interfaces in dpe_ifs.sv.
//
// A load word inserts one value into an eight-entry store kept in ascending
// order and restarts the enumeration; it shifts each larger entry up one
// position and then places the value in the hole. A next word resumes a
// backtracking search with one shared 16-bit comparator that examines one
// store position per cycle; a level that runs out of positions is noticed in
// the scan state and each step back a level passes through the pop state
// before the scan resumes. A word whose answer is known at once (exhausted)
// goes straight to the emit state. The block takes no new word while a load
// or search is in progress; a finished result sits in an output register so
// the next word can be accepted before it is taken. Any configuration write
// restarts the enumeration. No clearing pass runs after reset.
module distinct_permutation_enumerator_core
    import dpe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    dpe_req_if.sink            req_ch,
    dpe_res_if.source          res_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INS  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_POP  = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    // Control state
    logic [2:0]            state_reg, state_next;
    cnt_t                  item_count_reg, item_count_next;
    cnt_t                  tuple_length_reg, tuple_length_next;
    cnt_t                  loaded_reg, loaded_next;
    logic [MAX_ITEMS-1:0]  used_reg, used_next;
    logic                  started_reg, started_next;
    logic                  finished_reg, finished_next;
    cnt_t                  depth_reg, depth_next;
    cnt_t                  idx_reg, idx_next;
    cnt_t                  n_reg, n_next;
    logic                  have_prev_reg, have_prev_next;
    logic                  res_exh_reg, res_exh_next;
    logic                  out_valid_reg, out_valid_next;

    // Payload state
    value_t                store_reg [MAX_ITEMS];
    value_t                store_next [MAX_ITEMS];
    idx_t                  pick_reg [MAX_ITEMS];
    idx_t                  pick_next [MAX_ITEMS];
    value_t                pick_val_reg [MAX_ITEMS];
    value_t                pick_val_next [MAX_ITEMS];
    value_t                prev_val_reg, prev_val_next;
    value_t                ins_val_reg, ins_val_next;
    value_t                out_elem_reg [OUT_ELEMS];
    value_t                out_elem_next [OUT_ELEMS];
    logic                  out_exh_reg, out_exh_next;

    // Shared compare unit and helpers
    idx_t                  rd_addr;
    value_t                cmp_a;
    value_t                cmp_b;
    logic                  cmp_eq;
    logic                  cmp_gt;
    logic                  cfg_wr;
    logic                  out_free;
    cnt_t                  n_now;
    cnt_t                  depth_m1;
    idx_t                  pop_pos;

    // APB side
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_TUPLE_LENGTH)
                    ? {{(APB_DW-CNT_W){1'b0}}, tuple_length_reg}
                    : {{(APB_DW-CNT_W){1'b0}}, item_count_reg};

    // Channel side
    assign req_ch.ready     = (state_reg == ST_IDLE);
    assign res_ch.valid     = out_valid_reg;
    assign res_ch.elem_0    = out_elem_reg[0];
    assign res_ch.elem_1    = out_elem_reg[1];
    assign res_ch.elem_2    = out_elem_reg[2];
    assign res_ch.elem_3    = out_elem_reg[3];
    assign res_ch.elem_4    = out_elem_reg[4];
    assign res_ch.elem_5    = out_elem_reg[5];
    assign res_ch.elem_6    = out_elem_reg[6];
    assign res_ch.elem_7    = out_elem_reg[7];
    assign res_ch.exhausted = out_exh_reg;
    assign out_free         = !out_valid_reg || res_ch.ready;

    // Single read port: insertion looks one below the hole, search at idx
    assign rd_addr = (state_reg == ST_INS) ? idx_t'(idx_reg - 1'b1) : idx_reg[IDX_W-1:0];
    assign cmp_a   = store_reg[rd_addr];
    assign cmp_b   = (state_reg == ST_INS) ? ins_val_reg : prev_val_reg;
    assign cmp_eq  = (cmp_a == cmp_b);
    assign cmp_gt  = (cmp_a > cmp_b);

    // Positions in use and the pop target
    assign n_now    = (item_count_reg < loaded_reg) ? item_count_reg : loaded_reg;
    assign depth_m1 = depth_reg - 1'b1;
    assign pop_pos  = pick_reg[depth_m1[IDX_W-1:0]];

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        item_count_next   = item_count_reg;
        tuple_length_next = tuple_length_reg;
        loaded_next       = loaded_reg;
        used_next         = used_reg;
        started_next      = started_reg;
        finished_next     = finished_reg;
        depth_next        = depth_reg;
        idx_next          = idx_reg;
        n_next            = n_reg;
        have_prev_next    = have_prev_reg;
        res_exh_next      = res_exh_reg;
        out_valid_next    = out_valid_reg && !res_ch.ready;
        store_next        = store_reg;
        pick_next         = pick_reg;
        pick_val_next     = pick_val_reg;
        prev_val_next     = prev_val_reg;
        ins_val_next      = ins_val_reg;
        out_elem_next     = out_elem_reg;
        out_exh_next      = out_exh_reg;

        // Register writes restart the enumeration
        if (cfg_wr)
        begin
            if (paddr[2] == REG_TUPLE_LENGTH)
            begin
                tuple_length_next = pwdata[CNT_W-1:0];
            end
            else
            begin
                item_count_next = pwdata[CNT_W-1:0];
            end
            used_next     = '0;
            started_next  = 1'b0;
            finished_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_ch.valid)
                begin
                    if (req_ch.req_type == REQ_LOAD)
                    begin
                        used_next     = '0;
                        started_next  = 1'b0;
                        finished_next = 1'b0;
                        if (loaded_reg < item_count_reg && loaded_reg != cnt_t'(MAX_ITEMS))
                        begin
                            idx_next     = loaded_reg;
                            ins_val_next = req_ch.value;
                            state_next   = ST_INS;
                        end
                    end
                    else
                    begin
                        n_next = n_now;
                        if (finished_reg || tuple_length_reg > n_now)
                        begin
                            res_exh_next  = 1'b1;
                            finished_next = 1'b1;
                            state_next    = ST_EMIT;
                        end
                        else if (!started_reg)
                        begin
                            started_next   = 1'b1;
                            depth_next     = '0;
                            idx_next       = '0;
                            have_prev_next = 1'b0;
                            res_exh_next   = 1'b0;
                            // empty tuple is produced once
                            state_next = (tuple_length_reg == '0) ? ST_EMIT : ST_SCAN;
                        end
                        else if (tuple_length_reg == '0)
                        begin
                            res_exh_next  = 1'b1;
                            finished_next = 1'b1;
                            state_next    = ST_EMIT;
                        end
                        else
                        begin
                            // resume: undo the last pick first
                            res_exh_next = 1'b0;
                            depth_next   = tuple_length_reg;
                            state_next   = ST_POP;
                        end
                    end
                end
            end

            // Insertion: shift one larger entry up per cycle
            ST_INS:
            begin
                if (idx_reg != '0 && cmp_gt)
                begin
                    store_next[idx_reg[IDX_W-1:0]] = cmp_a;
                    idx_next = idx_reg - 1'b1;
                end
                else
                begin
                    store_next[idx_reg[IDX_W-1:0]] = ins_val_reg;
                    loaded_next = loaded_reg + 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            // Search: examine one position per cycle at the current depth
            ST_SCAN:
            begin
                if (idx_reg >= n_reg)
                begin
                    if (depth_reg == '0)
                    begin
                        res_exh_next  = 1'b1;
                        finished_next = 1'b1;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_POP;
                    end
                end
                else if (used_reg[idx_reg[IDX_W-1:0]] || (have_prev_reg && cmp_eq))
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    pick_next[depth_reg[IDX_W-1:0]]     = idx_reg[IDX_W-1:0];
                    pick_val_next[depth_reg[IDX_W-1:0]] = cmp_a;
                    used_next[idx_reg[IDX_W-1:0]]       = 1'b1;
                    if (depth_reg + 1'b1 == tuple_length_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        depth_next     = depth_reg + 1'b1;
                        idx_next       = '0;
                        have_prev_next = 1'b0;
                    end
                end
            end

            // Step back one level and continue after the old pick
            ST_POP:
            begin
                depth_next              = depth_m1;
                used_next[pop_pos]      = 1'b0;
                prev_val_next           = pick_val_reg[depth_m1[IDX_W-1:0]];
                have_prev_next          = 1'b1;
                idx_next                = cnt_t'(pop_pos) + 1'b1;
                state_next              = ST_SCAN;
            end

            // Hand the result word to the output register
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_exh_next   = res_exh_reg;
                    for (int k = 0; k < OUT_ELEMS; k++)
                    begin
                        if (!res_exh_reg && k < MAX_ITEMS && cnt_t'(k) < tuple_length_reg)
                        begin
                            out_elem_next[k] = pick_val_reg[k % MAX_ITEMS];
                        end
                        else
                        begin
                            out_elem_next[k] = '0;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            item_count_reg   <= cnt_t'(1);
            tuple_length_reg <= cnt_t'(1);
            loaded_reg       <= '0;
            used_reg         <= '0;
            started_reg      <= 1'b0;
            finished_reg     <= 1'b0;
            depth_reg        <= '0;
            idx_reg          <= '0;
            n_reg            <= '0;
            have_prev_reg    <= 1'b0;
            res_exh_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            item_count_reg   <= item_count_next;
            tuple_length_reg <= tuple_length_next;
            loaded_reg       <= loaded_next;
            used_reg         <= used_next;
            started_reg      <= started_next;
            finished_reg     <= finished_next;
            depth_reg        <= depth_next;
            idx_reg          <= idx_next;
            n_reg            <= n_next;
            have_prev_reg    <= have_prev_next;
            res_exh_reg      <= res_exh_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        store_reg    <= store_next;
        pick_reg     <= pick_next;
        pick_val_reg <= pick_val_next;
        prev_val_reg <= prev_val_next;
        ins_val_reg  <= ins_val_next;
        out_elem_reg <= out_elem_next;
        out_exh_reg  <= out_exh_next;
    end

    // One used mark per pick on the stack while searching
    a_used_matches_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_POP)
            |-> ($countones(used_reg) == 32'(depth_reg)))
        else $error("used marks out of step with search depth");

    // Scan never runs at or past the full tuple depth
    a_scan_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (depth_reg < tuple_length_reg))
        else $error("scan depth reached tuple length");

    // Scan position stays within the active positions
    a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= n_reg && n_reg <= cnt_t'(MAX_ITEMS)))
        else $error("scan position beyond active positions");

    // An exhausted result always leaves the enumeration finished
    a_exh_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && res_exh_reg) |-> finished_reg)
        else $error("exhausted result without finished flag");

endmodule
